[hdl/dam_pkg.sv]
// shared constants, types and hash function for the dram address map unit
`default_nettype none

package dam_pkg;

  localparam int ADDR_BITS      = 35;
  localparam int ROW_WIDTH      = 16;
  localparam int BANK_WIDTH     = 3;
  localparam int ROW_LSB        = 15;
  localparam int RAW_BANK_LSB   = 10;
  localparam int DEVICE_LSB     = ROW_LSB + ROW_WIDTH;
  localparam int DEVICE_BITS    = 4;
  localparam int COL_BITS       = 9;
  localparam int SUBPART_BIT    = 5;
  localparam int RAW_BANK_COUNT = 1 << BANK_WIDTH;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [ADDR_BITS-1:0] MASK_LOW_RST  = ADDR_BITS'(64'h6e574400);
  localparam logic [ADDR_BITS-1:0] MASK_MID_RST  = ADDR_BITS'(64'h39722800);
  localparam logic [ADDR_BITS-1:0] MASK_HIGH_RST = ADDR_BITS'(64'h4b9c1000);
  localparam logic [ADDR_BITS-1:0] MASK_CHAN_RST = ADDR_BITS'(64'hffff2400);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BANK_MASK_LOW  = 2'd0,
    CFG_BANK_MASK_MID  = 2'd1,
    CFG_BANK_MASK_HIGH = 2'd2,
    CFG_CHANNEL_MASK   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] low;
    logic [ADDR_BITS-1:0] mid;
    logic [ADDR_BITS-1:0] high;
    logic [ADDR_BITS-1:0] chan;
  } hash_masks_t;

  typedef struct packed {
    logic [BANK_WIDTH-1:0] bank;
    logic                  chan;
  } hash_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] addr;
  } neighbor_t;

  function automatic hash_t addr_hash(input logic [ADDR_BITS-1:0] a, input hash_masks_t m);
    hash_t h;
    h.bank = {^(a & m.high), ^(a & m.mid), ^(a & m.low)};
    h.chan = ^(a & m.chan);
    return h;
  endfunction

endpackage

`default_nettype wire

[hdl/dam_row_search.sv]
// same-bank, same-channel search over the raw bank values of one target row
`default_nettype none

module dam_row_search import dam_pkg::*; (
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [ROW_WIDTH-1:0] row_i,
  input  logic                 row_ok_i,
  input  hash_masks_t          masks_i,
  output neighbor_t            result_o
);

  logic [ADDR_BITS-1:0] base;
  hash_t                want_h;
  hash_t                base_h;
  logic [RAW_BANK_COUNT-1:0] hit;

  always_comb begin
    base = addr_i;
    base[ROW_LSB +: ROW_WIDTH] = row_i;
    base[RAW_BANK_LSB +: BANK_WIDTH] = '0;
    want_h = addr_hash(addr_i, masks_i);
    base_h = addr_hash(base, masks_i);
  end

  // hash is linear: hash(base | off) = hash(base) ^ hash(off)
  always_comb begin
    logic [ADDR_BITS-1:0] off;
    hit = '0;
    for (int i = 0; i < RAW_BANK_COUNT; i++) begin
      off = ADDR_BITS'(i) << RAW_BANK_LSB;
      hit[i] = (hash_t'(base_h ^ addr_hash(off, masks_i)) == want_h);
    end
  end

  // lowest raw bank that matches wins
  always_comb begin
    logic [BANK_WIDTH-1:0] pick;
    logic                  found;
    pick  = '0;
    found = 1'b0;
    for (int i = RAW_BANK_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pick  = BANK_WIDTH'(i);
        found = 1'b1;
      end
    end
    result_o.valid = found && row_ok_i;
    result_o.addr  = '0;
    if (found && row_ok_i) begin
      result_o.addr = base;
      result_o.addr[RAW_BANK_LSB +: BANK_WIDTH] = pick;
    end
  end

endmodule

`default_nettype wire

[hdl/dram_address_map_neighbor_row_unit.sv]
// an accepted address is held in the input register, and done_o beats once the result register is loaded
// throughput: one address per cycle, busy_o is never raised
// the path from the input register to the result register is the neighbor search
// (eight hash compares per direction on the 35-bit address)
// reset clears the input and output valid flags and loads the default hash masks
`default_nettype none

module dram_address_map_neighbor_row_unit import dam_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  output logic                    done_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [ADDR_BITS-1:0]    cfg_data_i,
  input  logic [ADDR_BITS-1:0]    phys_address_i,
  output logic [ROW_WIDTH-1:0]    row_index_o,
  output logic [COL_BITS-1:0]     column_index_o,
  output logic [BANK_WIDTH-1:0]   bank_index_o,
  output logic                    channel_index_o,
  output logic                    subpartition_bit_o,
  output logic [DEVICE_BITS-1:0]  device_index_o,
  output logic [ADDR_BITS-1:0]    above_address_o,
  output logic                    above_valid_o,
  output logic [ADDR_BITS-1:0]    below_address_o,
  output logic                    below_valid_o
);

  hash_masks_t          masks_q;
  logic                 in_valid_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 out_valid_q;

  logic [ROW_WIDTH-1:0] row;
  logic [ROW_WIDTH-1:0] row_up;
  logic [ROW_WIDTH-1:0] row_dn;
  hash_t                own_h;
  neighbor_t            above;
  neighbor_t            below;

  logic [ROW_WIDTH-1:0]   row_q;
  logic [COL_BITS-1:0]    col_q;
  hash_t                  hash_q;
  logic                   subpart_q;
  logic [DEVICE_BITS-1:0] device_q;
  neighbor_t              above_q;
  neighbor_t              below_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q.low  <= MASK_LOW_RST;
      masks_q.mid  <= MASK_MID_RST;
      masks_q.high <= MASK_HIGH_RST;
      masks_q.chan <= MASK_CHAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BANK_MASK_LOW:  masks_q.low  <= cfg_data_i;
        CFG_BANK_MASK_MID:  masks_q.mid  <= cfg_data_i;
        CFG_BANK_MASK_HIGH: masks_q.high <= cfg_data_i;
        CFG_CHANNEL_MASK:   masks_q.chan <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start_i && !busy_o;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      addr_q <= phys_address_i;
    end
  end

  assign row    = addr_q[ROW_LSB +: ROW_WIDTH];
  assign row_up = row + ROW_WIDTH'(1);
  assign row_dn = row - ROW_WIDTH'(1);
  assign own_h  = addr_hash(addr_q, masks_q);

  dam_row_search u_search_above (
    .addr_i   (addr_q),
    .row_i    (row_up),
    .row_ok_i (row != '1),
    .masks_i  (masks_q),
    .result_o (above)
  );

  dam_row_search u_search_below (
    .addr_i   (addr_q),
    .row_i    (row_dn),
    .row_ok_i (row != '0),
    .masks_i  (masks_q),
    .result_o (below)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      row_q     <= row;
      col_q     <= {addr_q[14:13], addr_q[9:6], addr_q[4:2]};
      hash_q    <= own_h;
      subpart_q <= addr_q[SUBPART_BIT];
      device_q  <= addr_q[DEVICE_LSB +: DEVICE_BITS];
      above_q   <= above;
      below_q   <= below;
    end
  end

  assign done_o             = out_valid_q;
  assign row_index_o        = row_q;
  assign column_index_o     = col_q;
  assign bank_index_o       = hash_q.bank;
  assign channel_index_o    = hash_q.chan;
  assign subpartition_bit_o = subpart_q;
  assign device_index_o     = device_q;
  assign above_address_o    = above_q.addr;
  assign above_valid_o      = above_q.valid;
  assign below_address_o    = below_q.addr;
  assign below_valid_o      = below_q.valid;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result beat without an accepted address");

  a_above_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && above_valid_o) |->
      (above_address_o[ROW_LSB +: ROW_WIDTH] == ROW_WIDTH'(row_index_o + ROW_WIDTH'(1))))
    else $error("above neighbor not in the next row");

  a_below_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && below_valid_o) |->
      (below_address_o[ROW_LSB +: ROW_WIDTH] == ROW_WIDTH'(row_index_o - ROW_WIDTH'(1))))
    else $error("below neighbor not in the previous row");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((above_valid_o || above_address_o == '0) &&
                (below_valid_o || below_address_o == '0)))
    else $error("invalid neighbor carries a nonzero address");

  a_edge_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!(above_valid_o && row_index_o == '1) && !(below_valid_o && row_index_o == '0)))
    else $error("neighbor reported past the row limit");

endmodule

`default_nettype wire
